// ===== rtl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Shared widths, page mark codes, action codes and the command and status
// words between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int SIZE_W     = 16;
    localparam int PAGE_IDX_W = 10;
    localparam int ACT_W      = 2;
    localparam int PAGE_BYTES = 8;
    localparam int PAGE_SHIFT = 3;
    // Room for the rounded-up page count of the largest byte size.
    localparam int NEED_W     = SIZE_W - PAGE_SHIFT + 1;

    typedef logic [1:0] mark_t;

    localparam mark_t MARK_FREE  = 2'd0;
    localparam mark_t MARK_USED  = 2'd1;
    localparam mark_t MARK_START = 2'd2;
    localparam mark_t MARK_END   = 2'd3;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WALK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SIZED = 2'd2;

    typedef logic [2:0] op_t;

    localparam op_t OP_NONE  = 3'd0;
    localparam op_t OP_CLEAR = 3'd1;
    localparam op_t OP_LOAD  = 3'd2;
    localparam op_t OP_SCAN  = 3'd3;
    localparam op_t OP_FILL  = 3'd4;
    localparam op_t OP_WALK  = 3'd5;
    localparam op_t OP_ZERO  = 3'd6;

    typedef struct packed {
        op_t  op;
        logic set_res;
        logic res_ok;
        logic res_grant;
    } ffpa_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             need_bad;
        logic             page_out;
        logic             need_zero;
        logic             found;
        logic             scan_fail;
        logic             fill_last;
        logic             walk_done;
        logic             zero_last;
        logic             clear_last;
    } ffpa_sts_t;

endpackage
`default_nettype wire

// ===== rtl/ffpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit page allocator controller
// Sequences the clearing pass, the allocate scan and fill, and both kinds of
// free, and raises the result strobe.
// ----------------------------------------------------------------------------
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ffpa_sts_t sts,
    output ffpa_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_ZERO = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.action)
                    ACT_ALLOC:
                    begin
                        if (sts.need_bad)
                        begin
                            cmd.set_res = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    ACT_WALK:
                    begin
                        if (sts.page_out)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_ok  = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    ACT_SIZED:
                    begin
                        if (sts.page_out || sts.need_zero)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_ok  = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ZERO;
                        end
                    end
                    default:
                    begin
                        cmd.set_res = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.found)
                begin
                    state_next = S_FILL;
                end
                else if (sts.scan_fail)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                if (sts.fill_last)
                begin
                    cmd.set_res   = 1'b1;
                    cmd.res_ok    = 1'b1;
                    cmd.res_grant = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (sts.walk_done)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_ok  = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_ZERO:
            begin
                cmd.op = OP_ZERO;
                if (sts.zero_last)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_ok  = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block did not return to idle after a result");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(done) || ($past(state_reg) == S_INIT)))
        else $error("busy dropped without a result or the end of the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== rtl/ffpa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit page allocator datapath
// Page mark memory with one write and one registered read port, the scan
// pointer, run counter and result registers.
// ----------------------------------------------------------------------------
module ffpa_dpath
    import ffpa_pkg::*;
#(
    parameter int PAGE_COUNT = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [SIZE_W-1:0]     size_bytes,
    input  wire logic [PAGE_IDX_W-1:0] page_index,
    input  wire ffpa_cmd_t             cmd,
    output ffpa_sts_t                  sts,
    output logic                       ok,
    output logic [PAGE_IDX_W-1:0]      start_page
);

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);
    localparam int CMP_W = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);
    localparam logic [CNT_W-1:0] COUNT_C  = CNT_W'(PAGE_COUNT);
    localparam logic [CNT_W-1:0] LAST_C   = CNT_W'(PAGE_COUNT - 1);
    localparam logic [CMP_W-1:0] COUNT_W  = CMP_W'(PAGE_COUNT);
    localparam logic [CMP_W-1:0] LAST_W   = CMP_W'(PAGE_COUNT - 1);

    mark_t page_mem [0:PAGE_COUNT-1];

    logic [ACT_W-1:0]      act_reg;
    logic [NEED_W-1:0]     need_reg;
    logic [PAGE_IDX_W-1:0] page_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      ptr_next;
    logic [IDX_W-1:0]      chk_reg;
    logic                  chk_vld_reg;
    logic                  chk_vld_next;
    logic [NEED_W-1:0]     run_reg;
    logic [NEED_W-1:0]     run_next;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      head_next;
    mark_t                 rd_mark_reg;
    logic                  ok_reg;
    logic [PAGE_IDX_W-1:0] start_reg;

    logic [SIZE_W:0]       round_sum;
    logic [NEED_W-1:0]     need_load;
    logic [CMP_W-1:0]      page_in_ext;
    logic [CMP_W-1:0]      page_ext;
    logic [CMP_W-1:0]      head_ext;
    logic [CMP_W-1:0]      fill_sum;
    logic [CMP_W-1:0]      zero_sum;
    logic [NEED_W-1:0]     need_m1;
    logic [NEED_W-1:0]     run_p1;
    logic                  rd_free;
    logic                  issue;
    logic                  found;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    mark_t                 mem_wdata;

    always_comb
    begin
        round_sum   = {1'b0, size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1);
        if (action == ACT_SIZED)
        begin
            need_load = NEED_W'(size_bytes >> PAGE_SHIFT);
        end
        else
        begin
            need_load = NEED_W'(round_sum >> PAGE_SHIFT);
        end
        page_in_ext = CMP_W'(page_index);
        page_ext    = CMP_W'(page_reg);
        head_ext    = CMP_W'(head_reg);
        fill_sum    = head_ext + CMP_W'(run_reg);
        zero_sum    = page_ext + CMP_W'(run_reg);
        need_m1     = need_reg - NEED_W'(1);
        run_p1      = run_reg + NEED_W'(1);
        rd_free     = (rd_mark_reg == MARK_FREE);
        issue       = ((cmd.op == OP_SCAN) || (cmd.op == OP_WALK)) && (ptr_reg < COUNT_C);
        found       = chk_vld_reg && rd_free && (run_p1 == need_reg);
    end

    always_comb
    begin
        sts.action     = act_reg;
        sts.need_bad   = (need_reg == '0) || (CMP_W'(need_reg) > COUNT_W);
        sts.page_out   = (page_ext >= COUNT_W);
        sts.need_zero  = (need_reg == '0);
        sts.found      = found;
        sts.scan_fail  = chk_vld_reg && !found && (chk_reg == LAST_IDX);
        sts.fill_last  = (run_reg == need_m1);
        sts.walk_done  = chk_vld_reg
                         && (rd_free || (rd_mark_reg == MARK_END) || (chk_reg == LAST_IDX));
        sts.zero_last  = (run_reg == need_m1) || (zero_sum == LAST_W);
        sts.clear_last = (ptr_reg == LAST_C);
    end

    // Pointer, run counter and head of the current free run.
    always_comb
    begin
        ptr_next     = ptr_reg;
        run_next     = run_reg;
        head_next    = head_reg;
        chk_vld_next = issue;
        case (cmd.op)
            OP_CLEAR:
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_LOAD:
            begin
                run_next = '0;
                if (action == ACT_ALLOC)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = page_in_ext[CNT_W-1:0];
                end
            end
            OP_SCAN:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (rd_free)
                    begin
                        if (run_reg == '0)
                        begin
                            head_next = chk_reg;
                        end
                        // The run counter becomes the fill offset once a run fits.
                        run_next = found ? '0 : run_p1;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
            end
            OP_WALK:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            OP_FILL, OP_ZERO:
            begin
                run_next = run_p1;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[IDX_W-1:0];
        mem_wdata = MARK_FREE;
        case (cmd.op)
            OP_CLEAR:
            begin
                mem_we = 1'b1;
            end
            OP_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_sum[IDX_W-1:0];
                if (run_reg == need_m1)
                begin
                    mem_wdata = MARK_END;
                end
                else if (run_reg == '0)
                begin
                    mem_wdata = MARK_START;
                end
                else
                begin
                    mem_wdata = MARK_USED;
                end
            end
            OP_WALK:
            begin
                mem_we    = chk_vld_reg && !rd_free;
                mem_waddr = chk_reg;
            end
            OP_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = zero_sum[IDX_W-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_mark_reg <= page_mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            run_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            run_reg     <= run_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        if (issue)
        begin
            chk_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.op == OP_LOAD)
        begin
            act_reg  <= action;
            need_reg <= need_load;
            page_reg <= page_index;
        end
        if (cmd.set_res)
        begin
            ok_reg    <= cmd.res_ok;
            start_reg <= cmd.res_grant ? head_ext[PAGE_IDX_W-1:0] : '0;
        end
    end

    assign ok         = ok_reg;
    assign start_page = start_reg;

`ifndef SYNTH
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && issue) |-> (mem_waddr != ptr_reg[IDX_W-1:0]))
        else $error("mark write and read-ahead hit the same page");

    a_chk_follows: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> ((CNT_W'(chk_reg) + CNT_W'(1)) == ptr_reg))
        else $error("checked page is not the one before the read pointer");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FILL) |-> (fill_sum < COUNT_W))
        else $error("block fill ran past the end of the table");
`endif

endmodule
`default_nettype wire

// ===== rtl/first_fit_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit page allocator
// Keeps a two-bit mark per page, grants the first free run that fits a byte
// size, and frees blocks by walking marks or by a given byte size.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Fields
//  command   start, busy            action, size_bytes, page_index
//  result    done (one-cycle pulse) ok, start_page
//
// After reset a clearing pass writes every page free, one page a cycle, so
// busy stays high until the pass ends and no word is taken before then.
// A word is taken when start is high and busy is low; its result follows.
// Allocate scans for the first free run that fits, then marks its pages.
// Walking free clears marks up to an end mark, a free page or the last page.
// Sized free clears whole pages. The mark memory's single read port sets the
// pace. The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int PAGE_COUNT = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [SIZE_W-1:0]     size_bytes,
    input  wire logic [PAGE_IDX_W-1:0] page_index,
    output logic                       done,
    output logic                       ok,
    output logic [PAGE_IDX_W-1:0]      start_page
);

    ffpa_cmd_t cmd;
    ffpa_sts_t sts;

    ffpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ffpa_dpath #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .size_bytes (size_bytes),
        .page_index (page_index),
        .cmd        (cmd),
        .sts        (sts),
        .ok         (ok),
        .start_page (start_page)
    );

endmodule
`default_nettype wire

// ===== tb/first_fit_page_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Sends allocate and free commands through the start/busy handshake and
// checks every result word against a page mark table kept in the bench.
// Frees mostly target live blocks so that the heap stays fragmented.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_test;
    import ffpa_pkg::*;

    localparam int PAGE_COUNT   = 1024;
    localparam int RANDOM_WORDS = 558;
    localparam int PHASE_WORDS  = 146;
    localparam int DRAIN_CYCLES = 2100;
    localparam int REPORT_LIMIT = 10;
    // Two copies of the mark table: one steers stimulus, one checks results.
    localparam int MODEL_PLAN   = 0;
    localparam int MODEL_LIVE   = 1;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]      act;
        logic [SIZE_W-1:0]     bytes;
        logic [PAGE_IDX_W-1:0] page;
        int                    idle_pct;
    } request_t;

    typedef struct {
        logic                  ok;
        logic [PAGE_IDX_W-1:0] first;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [ACT_W-1:0]      action = '0;
    logic [SIZE_W-1:0]     size_bytes = '0;
    logic [PAGE_IDX_W-1:0] page_index = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [PAGE_IDX_W-1:0] start_page;

    mark_t    heap_marks [2][PAGE_COUNT];
    request_t pending_requests [$];
    grant_t   expected_grants [$];
    logic     word_taken = 1'b0;
    int       words_total = 0;
    int       words_taken = 0;
    int       fail_count = 0;

    first_fit_page_allocator #(
        .PAGE_COUNT (PAGE_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .size_bytes (size_bytes),
        .page_index (page_index),
        .done       (done),
        .ok         (ok),
        .start_page (start_page)
    );

    always #5 clk = ~clk;

    // Applies one command to a copy of the mark table and returns its result.
    function automatic void apply_request(input int copy, input logic [ACT_W-1:0] act,
                                          input logic [SIZE_W-1:0] bytes,
                                          input logic [PAGE_IDX_W-1:0] page,
                                          output logic ok_o,
                                          output logic [PAGE_IDX_W-1:0] first_o);
        int    need;
        int    run;
        int    head;
        int    i;
        int    count;
        logic  fits;
        logic  stop;
        mark_t m;
        ok_o = 1'b0;
        first_o = '0;
        case (act)
            ACT_ALLOC:
            begin
                need = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
                run = 0;
                head = 0;
                fits = 1'b0;
                if (need != 0 && need <= PAGE_COUNT)
                begin
                    for (i = 0; i < PAGE_COUNT && !fits; i++)
                    begin
                        if (heap_marks[copy][i] == MARK_FREE)
                        begin
                            if (run == 0)
                                head = i;
                            run++;
                            if (run == need)
                                fits = 1'b1;
                        end
                        else
                            run = 0;
                    end
                end
                if (fits)
                begin
                    if (need == 1)
                        heap_marks[copy][head] = MARK_END;
                    else
                    begin
                        heap_marks[copy][head] = MARK_START;
                        for (i = head + 1; i < head + need - 1; i++)
                            heap_marks[copy][i] = MARK_USED;
                        heap_marks[copy][head + need - 1] = MARK_END;
                    end
                    ok_o = 1'b1;
                    first_o = head[PAGE_IDX_W-1:0];
                end
            end
            ACT_WALK:
            begin
                stop = 1'b0;
                for (i = int'(page); i < PAGE_COUNT && !stop; i++)
                begin
                    m = heap_marks[copy][i];
                    if (m == MARK_FREE)
                        stop = 1'b1;
                    else
                    begin
                        heap_marks[copy][i] = MARK_FREE;
                        if (m == MARK_END)
                            stop = 1'b1;
                    end
                end
                ok_o = 1'b1;
            end
            ACT_SIZED:
            begin
                count = int'(bytes) / PAGE_BYTES;
                for (i = 0; i < count && int'(page) + i < PAGE_COUNT; i++)
                    heap_marks[copy][int'(page) + i] = MARK_FREE;
                ok_o = 1'b1;
            end
            default:
                ok_o = 1'b0;
        endcase
    endfunction

    task automatic add_request(input logic [ACT_W-1:0] act, input int bytes, input int page);
        request_t              req;
        logic                  ok_d;
        logic [PAGE_IDX_W-1:0] first_d;
        int                    phase;
        req.act = act;
        req.bytes = bytes[SIZE_W-1:0];
        req.page = page[PAGE_IDX_W-1:0];
        phase = words_total / PHASE_WORDS;
        // The third phase would stall the receiver, which this block cannot do.
        case (phase)
            0: req.idle_pct = 0;
            1: req.idle_pct = 59;
            2: req.idle_pct = 0;
            default: req.idle_pct = 38;
        endcase
        apply_request(MODEL_PLAN, req.act, req.bytes, req.page, ok_d, first_d);
        pending_requests.push_back(req);
        words_total++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !(start && !word_taken))
        begin
            if (pending_requests.size() > 0 &&
                $urandom_range(99) >= pending_requests[0].idle_pct)
            begin
                start <= 1'b1;
                action <= pending_requests[0].act;
                size_bytes <= pending_requests[0].bytes;
                page_index <= pending_requests[0].page;
                void'(pending_requests.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : monitor
        grant_t grant;
        logic   ok_e;
        logic   [PAGE_IDX_W-1:0] first_e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                    flag_error($sformatf("unexpected result word ok=%0d start_page=%0d",
                                         ok, start_page));
                else
                begin
                    grant = expected_grants.pop_front();
                    if (ok !== grant.ok || start_page !== grant.first)
                        flag_error($sformatf({"result mismatch: expected ok=%0d ",
                                              "start_page=%0d, got ok=%0d start_page=%0d"},
                                             grant.ok, grant.first, ok, start_page));
                end
            end
            if (start && !busy)
            begin
                apply_request(MODEL_LIVE, action, size_bytes, page_index, ok_e, first_e);
                grant.ok = ok_e;
                grant.first = first_e;
                expected_grants.push_back(grant);
                words_taken++;
            end
        end
        word_taken <= start && !busy;
    end

    initial
    begin : stimulus
        int heads [$];
        int n;
        int p;
        int q;
        int h;
        int len;
        int pick;
        int bytes;
        for (p = 0; p < PAGE_COUNT; p++)
        begin
            heap_marks[MODEL_PLAN][p] = MARK_FREE;
            heap_marks[MODEL_LIVE][p] = MARK_FREE;
        end

        // Directed: size extremes, first fit into holes, no fit, clipping.
        add_request(ACT_ALLOC, 0, 0);
        add_request(ACT_ALLOC, 1, 0);
        add_request(ACT_ALLOC, 8, 0);
        add_request(ACT_ALLOC, 9, 0);
        add_request(ACT_ALLOC, 65535, 0);
        add_request(ACT_ALLOC, 8193, 0);
        add_request(ACT_UNUSED, 65535, 1023);
        add_request(ACT_WALK, 0, 1);
        add_request(ACT_ALLOC, 8, 0);
        add_request(ACT_WALK, 0, 5);
        add_request(ACT_WALK, 0, 2);
        add_request(ACT_SIZED, 7, 0);
        add_request(ACT_SIZED, 16, 0);
        add_request(ACT_ALLOC, 8192, 0);
        add_request(ACT_ALLOC, 1, 0);
        add_request(ACT_WALK, 0, 1000);
        add_request(ACT_ALLOC, 200, 0);
        add_request(ACT_ALLOC, 192, 0);
        add_request(ACT_SIZED, 65535, 1020);
        add_request(ACT_SIZED, 65528, 0);
        add_request(ACT_WALK, 65535, 1023);
        add_request(ACT_ALLOC, 24, 0);
        add_request(ACT_ALLOC, 8, 0);
        add_request(ACT_WALK, 0, 0);
        add_request(ACT_ALLOC, 16, 0);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // A block head is a marked page at page 0 or after a free page or an end mark.
            heads.delete();
            for (p = 0; p < PAGE_COUNT; p++)
                if (heap_marks[MODEL_PLAN][p] != MARK_FREE &&
                    (p == 0 || heap_marks[MODEL_PLAN][p-1] == MARK_FREE ||
                     heap_marks[MODEL_PLAN][p-1] == MARK_END))
                    heads.push_back(p);
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                case ($urandom_range(4))
                    0: add_request(ACT_UNUSED, $urandom_range(65535), $urandom_range(1023));
                    1: add_request(ACT_ALLOC, 0, $urandom_range(1023));
                    2: add_request(ACT_ALLOC, $urandom_range(65535, 8193), $urandom_range(1023));
                    3: add_request(ACT_WALK, $urandom_range(65535), $urandom_range(1023));
                    default: add_request(ACT_SIZED, $urandom_range(65535) >> $urandom_range(12),
                                         $urandom_range(1023));
                endcase
            end
            else if (heads.size() < 4 || (heads.size() < 40 && pick < 54))
            begin
                if ($urandom_range(9) != 0)
                    bytes = $urandom_range(160, 1);
                else
                    bytes = $urandom_range(8192, 161);
                add_request(ACT_ALLOC, bytes, $urandom_range(1023));
            end
            else
            begin
                h = heads[$urandom_range(heads.size() - 1)];
                q = h;
                while (q < PAGE_COUNT - 1 && heap_marks[MODEL_PLAN][q] != MARK_END &&
                       heap_marks[MODEL_PLAN][q+1] != MARK_FREE)
                    q++;
                len = q - h + 1;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: add_request(ACT_WALK, $urandom_range(65535), h);
                    6: add_request(ACT_WALK, $urandom_range(65535), h + $urandom_range(len - 1));
                    7, 8: add_request(ACT_SIZED, len * PAGE_BYTES + $urandom_range(7), h);
                    default:
                    begin
                        // Release one page too many or one too few.
                        if ($urandom_range(1) == 1)
                            add_request(ACT_SIZED, (len + 1) * PAGE_BYTES, h);
                        else
                            add_request(ACT_SIZED, (len - 1) * PAGE_BYTES, h);
                    end
                endcase
            end
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (words_taken < words_total)
            @(posedge clk);
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
